>>> hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> hdl/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int ZW               = 34;   // CORDIC datapath width, Q30
  localparam int TW               = 18;   // cos/sin width, Q16

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629712;
  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259424;
  localparam logic signed [ZW-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic [1:0] ORDER_123 = 2'd0;
  localparam logic [1:0] ORDER_321 = 2'd1;

  localparam logic [31:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    return $signed({2'b00, ATAN_TAB[idx]});
  endfunction

endpackage

>>> hdl/e2q_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of half a Q2.13 angle.
// ----------------------------------------------------------------------------
module e2q_cordic #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic [CORDIC_STEPS+1:0]          en,      // per-stage advance
  input  logic signed [15:0]               angle,
  output logic signed [e2q_pkg::TW-1:0]    cos_o,
  output logic signed [e2q_pkg::TW-1:0]    sin_o
);

  localparam int ZW = e2q_pkg::ZW;

  logic signed [ZW-1:0] x_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] y_r [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r [0:CORDIC_STEPS];
  logic                 neg_r [0:CORDIC_STEPS];

  logic signed [ZW-1:0] z_in;
  logic signed [ZW-1:0] z_fold_nxt;
  logic                 neg_nxt;

  // half angle in Q30 is the Q2.13 input times 2^16
  assign z_in = {{(ZW-32){angle[15]}}, angle, 16'h0000};

  always_comb begin
    z_fold_nxt = z_in;
    neg_nxt    = 1'b0;
    if (z_in > e2q_pkg::HALF_PI_Q30) begin
      z_fold_nxt = z_in - e2q_pkg::PI_Q30;
      neg_nxt    = 1'b1;
    end else if (z_in < -e2q_pkg::HALF_PI_Q30) begin
      z_fold_nxt = z_in + e2q_pkg::PI_Q30;
      neg_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r[0]   <= e2q_pkg::GAIN_Q30;
      y_r[0]   <= '0;
      z_r[0]   <= z_fold_nxt;
      neg_r[0] <= neg_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [ZW-1:0] xs, ys, at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = e2q_pkg::atan_q30(5'(i));

    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // Q30 -> Q16, round half up, then undo the fold
  logic signed [ZW-1:0] xq, yq;
  logic signed [e2q_pkg::TW-1:0] xc, yc;
  assign xq = (x_r[CORDIC_STEPS] + ZW'(8192)) >>> 14;
  assign yq = (y_r[CORDIC_STEPS] + ZW'(8192)) >>> 14;
  assign xc = xq[e2q_pkg::TW-1:0];
  assign yc = yq[e2q_pkg::TW-1:0];

  always_ff @(posedge clk) begin
    if (en[CORDIC_STEPS+1]) begin
      cos_o <= neg_r[CORDIC_STEPS] ? -xc : xc;
      sin_o <= neg_r[CORDIC_STEPS] ? -yc : yc;
    end
  end

endmodule

>>> hdl/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Euler angle triple (Q2.13 rad) to quaternion (Q1.14), 1-2-3 or 3-2-1.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer carries roll, pitch and yaw (signed Q2.13 radians).
//   out_* : one transfer carries w, x, y, z (signed Q1.14) in tdata and
//           the bad-order flag in tuser; components are zero when set.
//   cfg_* : rotation order, written while the block is idle
//           (0 = 1-2-3, 1 = 3-2-1, others flagged as bad order).
// Pipeline: fold, one stage per CORDIC iteration, round, two multiplier
// stages, sum, round/saturate.
// One triple per cycle unless the receiver stalls; the three angles run in
// parallel CORDIC lanes and the multiplier chain is fully pipelined.
// Reset clears all valid bits and sets the order to 3-2-1.
// When the receiver stalls, each stage holds only while its successor is
// full, so empty slots close up and in_tready drops once the pipe is full.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // roll_angle, pitch_angle, yaw_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        out_tuser,   // bad_order
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  localparam int TW    = e2q_pkg::TW;
  localparam int NST   = CORDIC_STEPS + 6;
  localparam int P1    = CORDIC_STEPS + 2;
  localparam int P2    = CORDIC_STEPS + 3;
  localparam int SUM   = CORDIC_STEPS + 4;
  localparam int FIN   = CORDIC_STEPS + 5;

  logic [1:0]     order_r;
  logic [NST-1:0] vld_r;
  logic [NST:0]   en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= e2q_pkg::ORDER_321;
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  // a stage advances when empty or when its successor advances
  assign en[NST] = out_tready;
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[FIN];

  logic signed [TW-1:0] c1, s1, c2, s2, c3, s3;

  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
    .clk(clk), .en(en[CORDIC_STEPS+1:0]), .angle($signed(in_tdata[15:0])),
    .cos_o(c1), .sin_o(s1)
  );
  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
    .clk(clk), .en(en[CORDIC_STEPS+1:0]), .angle($signed(in_tdata[31:16])),
    .cos_o(c2), .sin_o(s2)
  );
  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk(clk), .en(en[CORDIC_STEPS+1:0]), .angle($signed(in_tdata[47:32])),
    .cos_o(c3), .sin_o(s3)
  );

  // first products of angles 1 and 2
  logic signed [2*TW-1:0] cc_r, ss_r, sc_r, cs_r;
  logic signed [TW-1:0]   c3_r, s3_r;

  always_ff @(posedge clk) begin
    if (en[P1]) begin
      cc_r <= c1 * c2;
      ss_r <= s1 * s2;
      sc_r <= s1 * c2;
      cs_r <= c1 * s2;
      c3_r <= c3;
      s3_r <= s3;
    end
  end

  // triple products, exact Q48
  localparam int PW = 3*TW;
  logic signed [PW-1:0] ccc_r, sss_r, scc_r, css_r, csc_r, scs_r, ccs_r, ssc_r;

  always_ff @(posedge clk) begin
    if (en[P2]) begin
      ccc_r <= cc_r * c3_r;
      sss_r <= ss_r * s3_r;
      scc_r <= sc_r * c3_r;
      css_r <= cs_r * s3_r;
      csc_r <= cs_r * c3_r;
      scs_r <= sc_r * s3_r;
      ccs_r <= cc_r * s3_r;
      ssc_r <= ss_r * c3_r;
    end
  end

  localparam int SW = PW + 1;
  logic signed [SW-1:0] sw_r, sx_r, sy_r, sz_r;
  logic                 bad_r;

  always_ff @(posedge clk) begin
    if (en[SUM]) begin
      bad_r <= 1'b0;
      case (order_r)
        e2q_pkg::ORDER_123: begin
          sw_r <= SW'(ccc_r) - SW'(sss_r);
          sx_r <= SW'(scc_r) + SW'(css_r);
          sy_r <= SW'(csc_r) - SW'(scs_r);
          sz_r <= SW'(ccs_r) + SW'(ssc_r);
        end
        e2q_pkg::ORDER_321: begin
          sw_r <= SW'(ccc_r) + SW'(sss_r);
          sx_r <= SW'(scc_r) - SW'(css_r);
          sy_r <= SW'(csc_r) + SW'(scs_r);
          sz_r <= SW'(ccs_r) - SW'(ssc_r);
        end
        default: begin
          sw_r  <= '0;
          sx_r  <= '0;
          sy_r  <= '0;
          sz_r  <= '0;
          bad_r <= 1'b1;
        end
      endcase
    end
  end

  // Q48 -> Q14 round half up, saturate to +-1.0
  function automatic logic [15:0] finish(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = (s + (SW'(1) <<< 33)) >>> 34;
    if (r > SW'(16384))       return 16'sd16384;
    else if (r < -SW'(16384)) return -16'sd16384;
    else                      return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[FIN]) begin
      out_tdata <= {finish(sz_r), finish(sy_r), finish(sx_r), finish(sw_r)};
      out_tuser <= bad_r;
    end
  end

endmodule

>>> hdl/e2q_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks on the quaternion result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module e2q_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);

  logic signed [15:0] qw, qx, qy, qz;
  logic               in_rng;

  assign qw = $signed(out_tdata[15:0]);
  assign qx = $signed(out_tdata[31:16]);
  assign qy = $signed(out_tdata[47:32]);
  assign qz = $signed(out_tdata[63:48]);
  assign in_rng = (qw >= -16'sd16384) && (qw <= 16'sd16384) &&
                  (qx >= -16'sd16384) && (qx <= 16'sd16384) &&
                  (qy >= -16'sd16384) && (qy <= 16'sd16384) &&
                  (qz >= -16'sd16384) && (qz <= 16'sd16384);

  `ASSERT_NEXT_ALWAYS(a_rst_idle, clk, !rst_n, !out_tvalid)
  `ASSERT_IMPLY(a_bad_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 64'd0)
  `ASSERT_IMPLY(a_sat_range, clk, rst_n, out_tvalid, in_rng)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

>>> tb/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb
// Streams Euler angle triples through the converter under every rotation
// order and random handshake pressure; each quaternion is compared against
// a bit-exact fixed-point CORDIC and product-sum predictor.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [15:0] w;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [15:0] z;
  logic               bad;
} quat_t;

class quat_scoreboard;
  quat_t       pending[$];
  logic [1:0]  order;
  int          errors;
  int          checked;

  function new();
    order = e2q_pkg::ORDER_321;
    errors = 0;
    checked = 0;
  endfunction

  static function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  static function void half_cos_sin(logic [15:0] raw, output longint c, output longint s);
    longint z, x, y, xn;
    bit flip;
    z = longint'($signed(raw)) * 65536;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629712) begin
      z -= 64'sd3373259424;
      flip = 1;
    end else if (z < -64'sd1686629712) begin
      z += 64'sd3373259424;
      flip = 1;
    end
    for (int i = 0; i < e2q_pkg::CORDIC_STEPS_DEF && i < e2q_pkg::ATAN_ENTRIES; i++) begin
      if (z >= 0) begin
        xn = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= longint'(e2q_pkg::ATAN_TAB[i]);
      end else begin
        xn = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += longint'(e2q_pkg::ATAN_TAB[i]);
      end
      x = xn;
    end
    x = floor_shift(x + 8192, 14);
    y = floor_shift(y + 8192, 14);
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  static function logic signed [15:0] round_sat(longint sum);
    longint r;
    r = floor_shift(sum + (64'sd1 << 33), 34);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function void note_triple(logic [47:0] data);
    longint c1, s1, c2, s2, c3, s3;
    longint ccc, sss, scc, css, csc, scs, ccs, ssc;
    quat_t q;
    half_cos_sin(data[15:0], c1, s1);
    half_cos_sin(data[31:16], c2, s2);
    half_cos_sin(data[47:32], c3, s3);
    ccc = c1 * c2 * c3; sss = s1 * s2 * s3;
    scc = s1 * c2 * c3; css = c1 * s2 * s3;
    csc = c1 * s2 * c3; scs = s1 * c2 * s3;
    ccs = c1 * c2 * s3; ssc = s1 * s2 * c3;
    q = '0;
    if (order == e2q_pkg::ORDER_123) begin
      q.w = round_sat(ccc - sss); q.x = round_sat(scc + css);
      q.y = round_sat(csc - scs); q.z = round_sat(ccs + ssc);
    end else if (order == e2q_pkg::ORDER_321) begin
      q.w = round_sat(ccc + sss); q.x = round_sat(scc - css);
      q.y = round_sat(csc + scs); q.z = round_sat(ccs - ssc);
    end else begin
      q.bad = 1'b1;
    end
    pending.push_back(q);
  endfunction

  function void report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
  endfunction

  function void check_quat(logic [63:0] data, logic bad);
    quat_t e;
    checked++;
    if (pending.size() == 0) begin
      report("unexpected transfer", 0, 0);
      return;
    end
    e = pending.pop_front();
    if ($signed(data[15:0]) != e.w) report("quat_w", $signed(data[15:0]), e.w);
    if ($signed(data[31:16]) != e.x) report("quat_x", $signed(data[31:16]), e.x);
    if ($signed(data[47:32]) != e.y) report("quat_y", $signed(data[47:32]), e.y);
    if ($signed(data[63:48]) != e.z) report("quat_z", $signed(data[63:48]), e.z);
    if (bad != e.bad) report("bad_order", bad, e.bad);
  endfunction
endclass

module euler_to_quaternion_tb;
  localparam int LATENCY = e2q_pkg::CORDIC_STEPS_DEF + 6;
  localparam int WATCHDOG = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int idle_cycles = 0;
  int sent = 0;
  quat_scoreboard sb = new();

  always #5 clk = ~clk;

  euler_to_quaternion u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_wr_en, .cfg_wr_data
  );

  // receiver side, with an optional long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_quat(out_tdata, out_tuser);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(9))
      0: return 16'sd25736;
      1: return -16'sd25736;
      2: return 16'($urandom());
      default: return 16'(int'($urandom_range(51472)) - 25736);
    endcase
  endfunction

  // valid stays up after the accepting edge; the next call or drain() decides
  task automatic send_triple(logic [15:0] r, logic [15:0] p, logic [15:0] y);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {y, p, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_triple({y, p, r});
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_order(logic [1:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.order = val;
  endtask

  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) send_triple(pick_angle(), pick_angle(), pick_angle());
  endtask

  initial begin
    logic [15:0] edges[6];
    edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'h7FFF, 16'h8000, 16'sd12868};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset order is 3-2-1; directed extremes, including folded half angles
    for (int i = 0; i < 6; i++) send_triple(edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]);
    send_triple(16'hFFFF, 16'h0001, 16'h5555);
    write_order(e2q_pkg::ORDER_123);
    for (int i = 0; i < 6; i++) send_triple(edges[(i + 1) % 6], edges[i], edges[(i + 3) % 6]);
    write_order(2'd2);
    send_triple(16'sd1000, -16'sd2000, 16'sd3000);
    write_order(2'd3);
    send_triple(16'h7FFF, 16'h8000, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      write_order(ph % 4 == 3 ? 2'(2 + (ph / 4)) : 2'(ph % 2));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 2) hold_off = 200;
      random_burst(ph % 4 == 3 ? 30 : 70);
    end
    // sender waits for everything outstanding, then a final burst
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_order(e2q_pkg::ORDER_321);
    random_burst(40);
    drain();
    $display("Covered %0d angle triples, %0d quaternions checked, all rotation orders",
             sent, sb.checked);
    $display("including folded angles, a long output hold-off and idle/stall mixes.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/e2q_pkg.sv
hdl/e2q_cordic.sv
hdl/euler_to_quaternion.sv
hdl/e2q_checker.sv
tb/euler_to_quaternion_tb.sv
